### sv/jtkl_pkg.sv
package jtkl_pkg;

  // Width of the configuration data and index ports.
  localparam int CFG_DATA_WIDTH  = 64;
  localparam int CFG_INDEX_WIDTH = 1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_KEY_CHARS  = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_KEY_LENGTH = 1'd1;

  // Width of the key length register.
  localparam int KEY_LEN_WIDTH = 4;

  // Characters that steer the scanner.
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_OPEN      = 8'h7b;
  localparam logic [7:0] CH_CLOSE     = 8'h7d;
  localparam logic [7:0] CH_COLON     = 8'h3a;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_LF        = 8'h0a;

  // Candidate comparator phases.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_KEY  = 3'b010,
    PH_GAP  = 3'b100
  } phase_t;

  // One byte of JSON text.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One result per text.
  typedef struct packed {
    logic        found;
    logic [15:0] key_position;
  } out_item_t;

  // True for the whitespace allowed between the closing quote and the colon.
  function automatic logic is_gap(input logic [7:0] c);
    is_gap = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

endpackage

### sv/json_top_level_key_locator.sv
// Top-level JSON key locator.
// The input channel (in_valid, in_ready, in_data) carries the JSON text one
// byte per transaction; last_byte marks the final byte of a text. The output
// channel (out_valid, out_ready, out_data) carries one transaction per text:
// found, and the byte offset of the key's opening quote (zero if not found).
// The key is loaded through cfg_write, cfg_index and cfg_data: index 0 holds
// the key characters (first in the lowest byte), index 1 the key length.
// Throughput is one byte per cycle while in_ready is high; all scanner state is
// updated in the cycle the byte is accepted, so the result appears on the output
// register in the cycle after the last byte is accepted.
// The output register holds the result until it is taken. While it is full
// and out_ready is low, in_ready is low; otherwise a byte is taken every
// cycle, including the cycle in which the pending result leaves.
// Reset clears the scanner, empties the output register and sets the key
// characters to zero and the key length to one. No clearing pass runs.
module json_top_level_key_locator #(
  parameter int KEY_MAX_CHARS  = 8,
  parameter int POSITION_WIDTH = 16,
  parameter int DEPTH_WIDTH    = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  jtkl_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output jtkl_pkg::out_item_t                  out_data,
  input  logic                                 cfg_write,
  input  logic [jtkl_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [jtkl_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  import jtkl_pkg::*;

  localparam int KEY_BITS  = 8 * KEY_MAX_CHARS;
  localparam int IDX_WIDTH = $clog2(KEY_MAX_CHARS + 1);
  localparam logic [KEY_LEN_WIDTH-1:0] KEY_MAX_LEN = KEY_LEN_WIDTH'(KEY_MAX_CHARS);
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
  localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = '1;
  localparam logic [DEPTH_WIDTH-1:0] DEPTH_ONE = DEPTH_WIDTH'(1);

  // Configuration registers.
  logic [KEY_BITS-1:0]      key_chars;
  logic [KEY_LEN_WIDTH-1:0] key_length;

  // Scanner state.
  logic                      inside_string, inside_string_next;
  logic                      escape_pending, escape_pending_next;
  logic [DEPTH_WIDTH-1:0]    nesting_depth, nesting_depth_next;
  phase_t                    match_phase, match_phase_next;
  logic [IDX_WIDTH-1:0]      match_index, match_index_next;
  logic [POSITION_WIDTH-1:0] candidate_position, candidate_position_next;
  logic [POSITION_WIDTH-1:0] byte_count, byte_count_next;
  logic                      match_found, match_found_next;
  logic [POSITION_WIDTH-1:0] match_position, match_position_next;

  logic                      in_accept;
  logic [KEY_LEN_WIDTH-1:0]  len;
  logic [7:0]                want;
  logic [7:0]                c;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;
  assign c         = in_data.data_byte;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_chars  <= '0;
      key_length <= KEY_LEN_WIDTH'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_CHARS:  key_chars  <= cfg_data[KEY_BITS-1:0];
        REG_KEY_LENGTH: key_length <= cfg_data[KEY_LEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Effective key length and the key character under comparison.
  always_comb begin
    len  = (key_length > KEY_MAX_LEN) ? KEY_MAX_LEN : key_length;
    want = '0;
    for (int i = 0; i < KEY_MAX_CHARS; i++) begin
      if (match_index == IDX_WIDTH'(i)) begin
        want = key_chars[8*i +: 8];
      end
    end
  end

  // Per-byte update: candidate comparator first, then the structural scanner.
  always_comb begin
    inside_string_next      = inside_string;
    escape_pending_next     = escape_pending;
    nesting_depth_next      = nesting_depth;
    match_phase_next        = match_phase;
    match_index_next        = match_index;
    candidate_position_next = candidate_position;
    match_found_next        = match_found;
    match_position_next     = match_position;
    byte_count_next         = (byte_count < POS_MAX) ? byte_count + 1'b1 : byte_count;

    // Compare the raw bytes following a candidate's opening quote.
    unique case (match_phase)
      PH_KEY: begin
        if (KEY_LEN_WIDTH'(match_index) < len) begin
          if (c == want) begin
            match_index_next = match_index + 1'b1;
          end else begin
            match_phase_next = PH_IDLE;
          end
        end else if (c == CH_QUOTE) begin
          match_phase_next = PH_GAP;
        end else begin
          match_phase_next = PH_IDLE;
        end
      end
      PH_GAP: begin
        if (c == CH_COLON) begin
          if (!match_found) begin
            match_found_next    = 1'b1;
            match_position_next = candidate_position;
          end
          match_phase_next = PH_IDLE;
        end else if (!is_gap(c)) begin
          match_phase_next = PH_IDLE;
        end
      end
      default: match_phase_next = PH_IDLE;
    endcase

    // Track strings, escapes and brace depth; start a candidate at depth one.
    if (inside_string) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
      end else if (c == CH_BACKSLASH) begin
        escape_pending_next = 1'b1;
      end else if (c == CH_QUOTE) begin
        inside_string_next = 1'b0;
      end
    end else if (c == CH_QUOTE) begin
      inside_string_next = 1'b1;
      if (nesting_depth == DEPTH_ONE && match_phase_next == PH_IDLE && !match_found_next) begin
        match_phase_next        = PH_KEY;
        match_index_next        = '0;
        candidate_position_next = byte_count;
      end
    end else if (c == CH_OPEN) begin
      if (nesting_depth < DEPTH_MAX) begin
        nesting_depth_next = nesting_depth + 1'b1;
      end
    end else if (c == CH_CLOSE) begin
      if (nesting_depth != '0) begin
        nesting_depth_next = nesting_depth - 1'b1;
      end
    end
  end

  // Scanner state registers; reset and the last byte of a text clear them.
  always_ff @(posedge clk) begin
    if (rst || (in_accept && in_data.last_byte)) begin
      inside_string      <= 1'b0;
      escape_pending     <= 1'b0;
      nesting_depth      <= '0;
      match_phase        <= PH_IDLE;
      match_index        <= '0;
      candidate_position <= '0;
      byte_count         <= '0;
      match_found        <= 1'b0;
      match_position     <= '0;
    end else if (in_accept) begin
      inside_string      <= inside_string_next;
      escape_pending     <= escape_pending_next;
      nesting_depth      <= nesting_depth_next;
      match_phase        <= match_phase_next;
      match_index        <= match_index_next;
      candidate_position <= candidate_position_next;
      byte_count         <= byte_count_next;
      match_found        <= match_found_next;
      match_position     <= match_position_next;
    end
  end

  // Output register: loaded on the last byte, held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && in_data.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_data.last_byte) begin
      out_data.found        <= match_found_next;
      out_data.key_position <= match_found_next ? 16'(match_position_next) : 16'd0;
    end
  end

  // A last byte always leaves a result in the output register.
  assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.last_byte |=> out_valid)
    else $error("result not registered after last byte");

  // A new text starts from a cleared scanner.
  assert property (@(posedge clk) disable iff (rst)
    in_accept && in_data.last_byte |=> byte_count == '0 && match_phase == PH_IDLE)
    else $error("scanner not cleared after last byte");

  // No candidate is under comparison once a match has been recorded.
  assert property (@(posedge clk) disable iff (rst)
    match_phase != PH_IDLE |-> !match_found)
    else $error("candidate active after a match");

  // The recorded position stays zero until a match is found.
  assert property (@(posedge clk) disable iff (rst)
    !match_found |-> match_position == '0)
    else $error("match position set without a match");

endmodule
